/* rtl/bdq_pkg.sv */
// Package for the bounded deque: sizes, command codes, sequencer states,
// result types and circular slot arithmetic. No dependencies.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH  = 32;
    localparam int WORD_W = 32;
    localparam int KIND_W = 4;
    localparam int AMT_W  = 8;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > AMT_W) ? CNT_W : AMT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 4'd0,
        KIND_PUSH_BACK  = 4'd1,
        KIND_POP_FRONT  = 4'd2,
        KIND_POP_BACK   = 4'd3,
        KIND_REMOVE     = 4'd4,
        KIND_CLEAR      = 4'd5,
        KIND_READ_FIRST = 4'd6,
        KIND_READ_LAST  = 4'd7,
        KIND_READ_ALL   = 4'd8
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_REMOVE
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              status;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } land_t;

    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                    input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(DEPTH))
        begin
            sum = sum - (CNT_W+1)'(DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_inc(input logic [ADDR_W-1:0] a);
        return (a == ADDR_W'(DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_dec(input logic [ADDR_W-1:0] a);
        return (a == '0) ? ADDR_W'(DEPTH - 1) : a - 1'b1;
    endfunction

endpackage

`default_nettype wire

/* rtl/bdq_if.sv */
// Valid/ready channel interfaces for the deque: command in, result out.
// Depends on bdq_pkg.
`default_nettype none

interface bdq_cmd_if import bdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic signed [WORD_W-1:0] value;
    logic [AMT_W-1:0]         amount;

    modport source (output valid, kind, value, amount, input ready);
    modport sink   (input valid, kind, value, amount, output ready);
endinterface

interface bdq_res_if import bdq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] element_value;
    logic                     last;
    logic                     status;

    modport source (output valid, element_value, last, status, input ready);
    modport sink   (input valid, element_value, last, status, output ready);
endinterface

`default_nettype wire

/* rtl/bdq_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                               clk,
    input  wire logic                               we,
    input  wire logic [$clog2(DEPTH)-1:0]           waddr,
    input  wire logic [WIDTH-1:0]                   wdata,
    input  wire logic                               re,
    input  wire logic [$clog2(DEPTH)-1:0]           raddr,
    output logic      [WIDTH-1:0]                   rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/bdq_obuf.sv */
// Result buffer: output register plus skid entry, fed by landing read data.
// Depends on bdq_pkg and bdq_res_if.
`default_nettype none

module bdq_obuf import bdq_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire land_t  land,
    output logic        room,
    bdq_res_if.source   res
);

    logic  out_v_reg, out_v_next;
    logic  skid_v_reg, skid_v_next;
    item_t out_reg, out_next;
    item_t skid_reg, skid_next;
    logic  take;
    logic [1:0] occ;

    assign take = out_v_reg && res.ready;
    assign occ  = 2'(out_v_reg) + 2'(skid_v_reg) + 2'(land.valid);
    assign room = (occ - 2'(take)) < 2'd2;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        out_next    = out_reg;
        skid_next   = skid_reg;
        if (!out_v_reg || take)
        begin
            if (skid_v_reg)
            begin
                out_v_next  = 1'b1;
                out_next    = skid_reg;
                skid_v_next = land.valid;
                skid_next   = land.item;
            end
            else
            begin
                out_v_next = land.valid;
                out_next   = land.item;
            end
        end
        else if (land.valid)
        begin
            skid_v_next = 1'b1;
            skid_next   = land.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid         = out_v_reg;
    assign res.element_value = out_reg.word;
    assign res.last          = out_reg.last;
    assign res.status        = out_reg.status;

endmodule

`default_nettype wire

/* rtl/bounded_deque_with_value_removal.sv */
// Bounded deque of signed words with value removal, stored in a circular RAM.
// Push, pop and clear are done without leaving the idle state; a full-store push returns one result.
// Reads issue one RAM read per cycle while the result buffer has room, through the RAM read register.
// Removal scans and compacts through the RAM port; the sequencer stays busy until the scan ends.
// Reset clears state, front pointer, count and valid flags; RAM contents stay undefined.
`default_nettype none

module bounded_deque_with_value_removal import bdq_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_cmd_if.sink   cmd,
    bdq_res_if.source res
);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ADDR_W-1:0]   rd_slot_reg, rd_slot_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]    rd_pos_reg, rd_pos_next;
    logic [CNT_W-1:0]    wr_pos_reg, wr_pos_next;
    logic [WORD_W-1:0]   match_reg, match_next;
    logic                rm_pend_reg, rm_pend_next;
    logic                pend_v_reg, pend_v_next;
    logic                pend_last_reg, pend_last_next;
    logic                pend_status_reg, pend_status_next;
    logic [WORD_W-1:0]   pend_word_reg, pend_word_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    land_t               land;
    logic                room;
    logic                accept;
    logic                full;
    logic [AMT_W-1:0]    amt_eff;
    logic [CMP_W-1:0]    amt_ext;
    logic [CNT_W-1:0]    n_sel;

    bdq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bdq_obuf u_obuf (
        .clk   (clk),
        .rst_n (rst_n),
        .land  (land),
        .room  (room),
        .res   (res)
    );

    assign land.valid       = pend_v_reg;
    assign land.item.word   = pend_status_reg ? pend_word_reg : ram_rdata;
    assign land.item.last   = pend_last_reg;
    assign land.item.status = pend_status_reg;

    assign cmd.ready = (state_reg == ST_IDLE) && room;
    assign accept    = cmd.valid && cmd.ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign amt_eff   = (cmd.amount == '0) ? AMT_W'(1) : cmd.amount;
    assign amt_ext   = CMP_W'(amt_eff);
    assign n_sel     = (amt_ext < CMP_W'(count_reg)) ? CNT_W'(amt_ext) : count_reg;

    always_comb
    begin
        state_next       = state_reg;
        front_next       = front_reg;
        count_next       = count_reg;
        rd_slot_next     = rd_slot_reg;
        rem_next         = rem_reg;
        rd_pos_next      = rd_pos_reg;
        wr_pos_next      = wr_pos_reg;
        match_next       = match_reg;
        rm_pend_next     = 1'b0;
        pend_v_next      = 1'b0;
        pend_last_next   = pend_last_reg;
        pend_status_next = pend_status_reg;
        pend_word_next   = pend_word_reg;
        ram_we           = 1'b0;
        ram_waddr        = '0;
        ram_wdata        = '0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.kind)
                        KIND_PUSH_FRONT, KIND_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                pend_v_next      = 1'b1;
                                pend_last_next   = 1'b1;
                                pend_status_next = 1'b1;
                                pend_word_next   = cmd.value;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_wdata  = cmd.value;
                                count_next = count_reg + 1'b1;
                                if (cmd.kind == KIND_PUSH_FRONT)
                                begin
                                    front_next = slot_dec(front_reg);
                                    ram_waddr  = slot_dec(front_reg);
                                end
                                else
                                begin
                                    ram_waddr = slot_add(front_reg, count_reg);
                                end
                            end
                        end
                        KIND_POP_FRONT:
                        begin
                            if (count_reg != '0)
                            begin
                                front_next = slot_inc(front_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_POP_BACK:
                        begin
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_REMOVE:
                        begin
                            match_next  = cmd.value;
                            rd_pos_next = '0;
                            wr_pos_next = '0;
                            state_next  = ST_REMOVE;
                        end
                        KIND_CLEAR:
                        begin
                            front_next = '0;
                            count_next = '0;
                        end
                        KIND_READ_FIRST:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_slot_next = front_reg;
                                rem_next     = n_sel;
                                state_next   = ST_READ;
                            end
                        end
                        KIND_READ_LAST:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_slot_next = slot_add(front_reg, count_reg - n_sel);
                                rem_next     = n_sel;
                                state_next   = ST_READ;
                            end
                        end
                        KIND_READ_ALL:
                        begin
                            if (count_reg != '0)
                            begin
                                rd_slot_next = front_reg;
                                rem_next     = count_reg;
                                state_next   = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (room)
                begin
                    ram_re           = 1'b1;
                    ram_raddr        = rd_slot_reg;
                    pend_v_next      = 1'b1;
                    pend_status_next = 1'b0;
                    pend_last_next   = (rem_reg == CNT_W'(1));
                    rd_slot_next     = slot_inc(rd_slot_reg);
                    rem_next         = rem_reg - 1'b1;
                    if (rem_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_REMOVE:
            begin
                if (rd_pos_reg < count_reg)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = slot_add(front_reg, rd_pos_reg);
                    rd_pos_next  = rd_pos_reg + 1'b1;
                    rm_pend_next = 1'b1;
                end
                // keep entries that differ, packed toward the front
                if (rm_pend_reg && (ram_rdata != match_reg))
                begin
                    ram_we      = 1'b1;
                    ram_waddr   = slot_add(front_reg, wr_pos_reg);
                    ram_wdata   = ram_rdata;
                    wr_pos_next = wr_pos_reg + 1'b1;
                end
                if ((rd_pos_reg == count_reg) && !rm_pend_reg)
                begin
                    count_next = wr_pos_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            front_reg   <= '0;
            count_reg   <= '0;
            rem_reg     <= '0;
            rd_pos_reg  <= '0;
            wr_pos_reg  <= '0;
            rm_pend_reg <= 1'b0;
            pend_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            front_reg   <= front_next;
            count_reg   <= count_next;
            rem_reg     <= rem_next;
            rd_pos_reg  <= rd_pos_next;
            wr_pos_reg  <= wr_pos_next;
            rm_pend_reg <= rm_pend_next;
            pend_v_reg  <= pend_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_slot_reg     <= rd_slot_next;
        match_reg       <= match_next;
        pend_last_reg   <= pend_last_next;
        pend_status_reg <= pend_status_next;
        pend_word_reg   <= pend_word_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("stored count exceeds depth");

    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.ready)
        else $error("command ready while sequencer busy");

    a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full && ((cmd.kind == KIND_PUSH_FRONT) || (cmd.kind == KIND_PUSH_BACK)))
        |=> (pend_v_reg && pend_status_reg && pend_last_reg))
        else $error("dropped push did not produce overflow result");

    a_compact_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE) |-> (wr_pos_reg <= rd_pos_reg))
        else $error("compaction write overtook read");
`endif

endmodule

`default_nettype wire
